>>> rtl/wrle_pkg.sv
// Shared constants and types of the word run-length encoder.
package wrle_pkg;

  localparam int unsigned LIT_DEPTH = 32;
  localparam int unsigned LIT_AW    = $clog2(LIT_DEPTH);
  localparam int unsigned LIT_CW    = $clog2(LIT_DEPTH + 1);

  localparam logic [LIT_CW-1:0] LIT_FULL  = LIT_CW'(LIT_DEPTH);
  localparam logic [15:0]       LIT_FLAG  = 16'h8000;
  localparam logic [14:0]       RUN_MAX   = 15'h7fff;
  localparam logic [3:0]        THR_RESET = 4'd4;

  // One request from the sequencer to the output stage.
  typedef struct packed {
    logic        emit;    // Push a new stream word.
    logic        finish;  // Release the held word as the last one of the request.
    logic [15:0] word;
    logic        hdr;
    logic        frame;   // Current request closes a frame.
  } wrle_oreq_t;

endpackage

>>> rtl/wrle_if.sv
// Valid/ready channel interfaces for input words and encoded stream words.
interface wrle_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_word;
  logic        end_of_frame;

  modport source (output valid, output pixel_word, output end_of_frame, input ready);
  modport sink   (input valid, input pixel_word, input end_of_frame, output ready);
endinterface

interface wrle_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_word;
  logic        is_header;
  logic        last_of_burst;
  logic        frame_done;

  modport source (output valid, output out_word, output is_header,
                  output last_of_burst, output frame_done, input ready);
  modport sink   (input valid, input out_word, input is_header,
                  input last_of_burst, input frame_done, output ready);
endinterface

>>> rtl/wrle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wrle_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/wrle_outq.sv
// Output stage: one holding register plus the output register of the stream.
module wrle_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wrle_pkg::wrle_oreq_t req_i,
  output logic                room_o,
  wrle_out_if.source          enc_o
);

  logic        out_v_q, out_v_d;
  logic [15:0] out_word_q, out_word_d;
  logic        out_hdr_q, out_hdr_d;
  logic        out_last_q, out_last_d;
  logic        out_fd_q, out_fd_d;
  logic        hold_v_q, hold_v_d;
  logic [15:0] hold_word_q, hold_word_d;
  logic        hold_hdr_q, hold_hdr_d;
  logic        out_free;

  // The held word moves on only once we know whether it ends the request.
  assign out_free = !out_v_q || enc_o.ready;
  assign room_o   = !hold_v_q || out_free;

  always_comb begin
    out_v_d     = out_v_q;
    out_word_d  = out_word_q;
    out_hdr_d   = out_hdr_q;
    out_last_d  = out_last_q;
    out_fd_d    = out_fd_q;
    hold_v_d    = hold_v_q;
    hold_word_d = hold_word_q;
    hold_hdr_d  = hold_hdr_q;

    if (out_v_q && enc_o.ready) begin
      out_v_d = 1'b0;
    end

    if ((req_i.emit || req_i.finish) && hold_v_q) begin
      out_v_d    = 1'b1;
      out_word_d = hold_word_q;
      out_hdr_d  = hold_hdr_q;
      out_last_d = req_i.finish;
      out_fd_d   = req_i.finish && req_i.frame;
      hold_v_d   = 1'b0;
    end

    if (req_i.emit) begin
      hold_v_d    = 1'b1;
      hold_word_d = req_i.word;
      hold_hdr_d  = req_i.hdr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      hold_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    out_hdr_q   <= out_hdr_d;
    out_last_q  <= out_last_d;
    out_fd_q    <= out_fd_d;
    hold_word_q <= hold_word_d;
    hold_hdr_q  <= hold_hdr_d;
  end

  assign enc_o.valid         = out_v_q;
  assign enc_o.out_word      = out_word_q;
  assign enc_o.is_header     = out_hdr_q;
  assign enc_o.last_of_burst = out_last_q;
  assign enc_o.frame_done    = out_fd_q;

endmodule

>>> rtl/word_rle_literal_run_encoder_core.sv
// Top level of the word run-length encoder with literal runs.
// Extending a run passes the decide, run-increment and finish states before the next request
// is taken; a new literal word also passes the close and new-word states.
// A literal flush reads each RAM word ahead and sends one per cycle while the output has room.
// Requests are taken one at a time; the output stage buffers the sequencer from the sink.
// Reset clears the counters, sets the threshold to four and arms the start of a frame;
// the literal RAM is not cleared, since only entries written in the current literal are read.
module word_rle_literal_run_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  wrle_in_if.sink    pix_i,
  wrle_out_if.source enc_o
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECIDE    = 4'd1;
  localparam logic [3:0] S_RUNINC    = 4'd2;
  localparam logic [3:0] S_SAT_H     = 4'd3;
  localparam logic [3:0] S_SAT_V     = 4'd4;
  localparam logic [3:0] S_NEWWORD   = 4'd5;
  localparam logic [3:0] S_EOFCHK    = 4'd6;
  localparam logic [3:0] S_CLOSE     = 4'd7;
  localparam logic [3:0] S_CR_H      = 4'd8;
  localparam logic [3:0] S_CR_V      = 4'd9;
  localparam logic [3:0] S_CR_P      = 4'd10;
  localparam logic [3:0] S_FL_HDR    = 4'd11;
  localparam logic [3:0] S_FL_DAT    = 4'd12;
  localparam logic [3:0] S_EOF_FLUSH = 4'd13;
  localparam logic [3:0] S_FIN       = 4'd14;

  logic [3:0]                    state_q, state_d;
  logic [3:0]                    close_ret_q, close_ret_d;
  logic [3:0]                    flush_ret_q, flush_ret_d;
  logic [15:0]                   word_q, word_d;
  logic                          eof_q, eof_d;
  logic [15:0]                   prev_q, prev_d;
  logic                          fs_q, fs_d;
  logic [14:0]                   run_q, run_d;
  logic [wrle_pkg::LIT_CW-1:0]   lit_q, lit_d;
  logic [wrle_pkg::LIT_AW-1:0]   k_q, k_d;
  logic [3:0]                    thr_q, thr_d;

  logic                          ram_we;
  logic [15:0]                   ram_wdata;
  logic                          ram_re;
  logic [wrle_pkg::LIT_AW-1:0]   ram_raddr;
  logic [15:0]                   ram_rdata;

  wrle_pkg::wrle_oreq_t          oreq;
  logic                          room;

  logic                          accept;
  logic [3:0]                    after_body;
  logic [3:0]                    thr_eff;
  logic [wrle_pkg::LIT_CW-1:0]   lit_inc;
  logic                          push_full;
  logic [wrle_pkg::LIT_CW-1:0]   k_inc;
  logic [3:0]                    cr_next;

  assign pix_i.ready = (state_q == S_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;

  // Once the word itself is handled, a frame end still has to close the run and literal.
  assign after_body = eof_q ? S_EOFCHK : S_FIN;
  // A threshold of zero behaves like one.
  assign thr_eff    = (thr_q == 4'd0) ? 4'd1 : thr_q;
  // A push always lands at the current fill level; reaching the depth forces a flush.
  assign lit_inc    = lit_q + 1'b1;
  assign push_full  = (lit_inc == wrle_pkg::LIT_FULL);
  assign k_inc      = wrle_pkg::LIT_CW'(k_q) + 1'b1;
  assign cr_next    = (run_q == 15'd1) ? close_ret_q : S_CR_P;
  assign ram_wdata  = (state_q == S_CR_P) ? prev_q : word_q;

  always_comb begin
    state_d     = state_q;
    close_ret_d = close_ret_q;
    flush_ret_d = flush_ret_q;
    word_d      = word_q;
    eof_d       = eof_q;
    prev_d      = prev_q;
    fs_d        = fs_q;
    run_d       = run_q;
    lit_d       = lit_q;
    k_d         = k_q;
    thr_d       = thr_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = k_q;
    oreq        = '0;
    oreq.frame  = eof_q;

    if (cfg_we_i) begin
      thr_d = cfg_wdata_i;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          word_d  = pix_i.pixel_word;
          eof_d   = pix_i.end_of_frame;
          // The first word of a frame starts a run of one.
          if (fs_q) begin
            prev_d = pix_i.pixel_word;
            run_d  = '0;
            lit_d  = '0;
            fs_d   = 1'b0;
          end
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (word_q == prev_q) begin
          if (eof_q && (lit_q != '0)) begin
            // A repeat on the last word joins the pending literal.
            ram_we = 1'b1;
            lit_d  = lit_inc;
            if (push_full) begin
              flush_ret_d = after_body;
              state_d     = S_FL_HDR;
            end else begin
              state_d = after_body;
            end
          end else if (lit_q != '0) begin
            // A repeat begins: the literal goes out first.
            flush_ret_d = S_RUNINC;
            state_d     = S_FL_HDR;
          end else begin
            state_d = S_RUNINC;
          end
        end else begin
          close_ret_d = S_NEWWORD;
          state_d     = S_CLOSE;
        end
      end

      S_RUNINC: begin
        if (run_q == (wrle_pkg::RUN_MAX - 15'd1)) begin
          run_d   = '0;
          state_d = S_SAT_H;
        end else begin
          run_d   = run_q + 15'd1;
          state_d = after_body;
        end
      end

      S_SAT_H: begin
        if (room) begin
          oreq.emit = 1'b1;
          oreq.word = {1'b0, wrle_pkg::RUN_MAX};
          oreq.hdr  = 1'b1;
          state_d   = S_SAT_V;
        end
      end

      S_SAT_V: begin
        if (room) begin
          oreq.emit = 1'b1;
          oreq.word = prev_q;
          state_d   = after_body;
        end
      end

      S_NEWWORD: begin
        prev_d = word_q;
        ram_we = 1'b1;
        lit_d  = lit_inc;
        if (push_full) begin
          flush_ret_d = after_body;
          state_d     = S_FL_HDR;
        end else begin
          state_d = after_body;
        end
      end

      S_EOFCHK: begin
        close_ret_d = S_EOF_FLUSH;
        state_d     = S_CLOSE;
      end

      S_CLOSE: begin
        if (run_q == '0) begin
          state_d = close_ret_q;
        end else if (run_q > 15'(thr_eff)) begin
          state_d = S_CR_H;
        end else begin
          state_d = S_CR_P;
        end
      end

      S_CR_H: begin
        if (room) begin
          oreq.emit = 1'b1;
          oreq.word = {1'b0, run_q};
          oreq.hdr  = 1'b1;
          state_d   = S_CR_V;
        end
      end

      S_CR_V: begin
        if (room) begin
          oreq.emit = 1'b1;
          oreq.word = prev_q;
          run_d     = '0;
          state_d   = close_ret_q;
        end
      end

      S_CR_P: begin
        // A short run is copied into the literal one word per cycle, paused by any flush it forces.
        ram_we = 1'b1;
        lit_d  = lit_inc;
        run_d  = run_q - 15'd1;
        if (push_full) begin
          flush_ret_d = cr_next;
          state_d     = S_FL_HDR;
        end else begin
          state_d = cr_next;
        end
      end

      S_FL_HDR: begin
        if (room) begin
          oreq.emit = 1'b1;
          oreq.word = wrle_pkg::LIT_FLAG | 16'(lit_q);
          oreq.hdr  = 1'b1;
          ram_re    = 1'b1;
          ram_raddr = '0;
          k_d       = '0;
          state_d   = S_FL_DAT;
        end
      end

      S_FL_DAT: begin
        // Read data holds while the output stage is full.
        if (room) begin
          oreq.emit = 1'b1;
          oreq.word = ram_rdata;
          if (k_inc < lit_q) begin
            ram_re    = 1'b1;
            ram_raddr = k_inc[wrle_pkg::LIT_AW-1:0];
            k_d       = k_inc[wrle_pkg::LIT_AW-1:0];
          end else begin
            lit_d   = '0;
            state_d = flush_ret_q;
          end
        end
      end

      S_EOF_FLUSH: begin
        if (lit_q != '0) begin
          flush_ret_d = S_FIN;
          state_d     = S_FL_HDR;
        end else begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (room) begin
          oreq.finish = 1'b1;
          fs_d        = eof_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      close_ret_q <= S_IDLE;
      flush_ret_q <= S_IDLE;
      prev_q      <= '0;
      fs_q        <= 1'b1;
      run_q       <= '0;
      lit_q       <= '0;
      k_q         <= '0;
      thr_q       <= wrle_pkg::THR_RESET;
    end else begin
      state_q     <= state_d;
      close_ret_q <= close_ret_d;
      flush_ret_q <= flush_ret_d;
      prev_q      <= prev_d;
      fs_q        <= fs_d;
      run_q       <= run_d;
      lit_q       <= lit_d;
      k_q         <= k_d;
      thr_q       <= thr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    eof_q  <= eof_d;
  end

  // Literal buffer: written at the fill level, read back in order on a flush.
  wrle_ram #(
    .Width (16),
    .Depth (wrle_pkg::LIT_DEPTH)
  ) u_lit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (lit_q[wrle_pkg::LIT_AW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wrle_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (oreq),
    .room_o (room),
    .enc_o  (enc_o)
  );

endmodule

>>> bench/word_rle_literal_run_encoder_core_tb.sv
// Self-checking testbench for the word run-length encoder with literal runs.
module word_rle_literal_run_encoder_core_tb;

  // Cycles to let pass once the last expected word has arrived, so that a request
  // that caused no stream word is finished before the threshold changes.
  localparam int unsigned SETTLE_CYCLES = 16;
  // Least number of words sent in the random part, counted from its start.
  localparam int unsigned RANDOM_WORDS  = 100;
  // Hard stop; the slowest correct run stays well below this.
  localparam longint unsigned RUN_LIMIT = 64'd30_000_000;

  // One word of the encoded stream, with its side flags.
  typedef struct packed {
    logic [15:0] word;
    logic        hdr;
    logic        burst_end;
    logic        frame_end;
  } enc_word_t;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  wrle_in_if  pix ();
  wrle_out_if enc ();

  word_rle_literal_run_encoder_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix),
    .enc_o       (enc)
  );

  always #5 clk_i = ~clk_i;

  // Stream words still owed by the encoder, oldest first.
  enc_word_t   owed_words[$];
  // Words produced by the request being predicted.
  enc_word_t   burst_words[$];

  int unsigned err_count  = 0;
  int unsigned words_sent = 0;
  int unsigned src_max_gap;
  int unsigned snk_max_gap;

  // Predictor state: mirrors the encoder's registers and literal buffer.
  logic [3:0]  thr;
  logic [15:0] prev_w;
  bit          frame_armed;
  int unsigned run_len;
  int unsigned lit_len;
  logic [15:0] lit_mem [wrle_pkg::LIT_DEPTH];

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor of the encoded stream
  // ---------------------------------------------------------------------------

  function automatic void emit_word(input logic [15:0] w, input logic hdr);
    burst_words.push_back('{word: w, hdr: hdr, burst_end: 1'b0, frame_end: 1'b0});
  endfunction

  // A literal goes out as its count with the top bit set, then its words.
  function automatic void emit_literal();
    if (lit_len == 0) begin
      return;
    end
    emit_word(16'(lit_len) | wrle_pkg::LIT_FLAG, 1'b1);
    for (int unsigned k = 0; k < lit_len && k < wrle_pkg::LIT_DEPTH; k++) begin
      emit_word(lit_mem[k], 1'b0);
    end
    lit_len = 0;
  endfunction

  // A full buffer is flushed at once.
  function automatic void append_literal(input logic [15:0] w);
    if (lit_len < wrle_pkg::LIT_DEPTH) begin
      lit_mem[lit_len] = w;
    end
    lit_len++;
    if (lit_len >= wrle_pkg::LIT_DEPTH) begin
      emit_literal();
    end
  endfunction

  // A run longer than the threshold becomes a count/value pair; any other run
  // is copied word by word into the literal. A threshold of zero counts as one.
  function automatic void close_run();
    int unsigned limit;
    limit = (thr == 4'd0) ? 1 : int'(thr);
    if (run_len == 0) begin
      return;
    end
    if (run_len > limit) begin
      emit_word(16'(run_len & 32'h7fff), 1'b1);
      emit_word(prev_w, 1'b0);
    end else begin
      for (int unsigned k = 0; k < run_len; k++) begin
        append_literal(prev_w);
      end
    end
    run_len = 0;
  endfunction

  // Works out the stream words caused by one accepted request and queues them.
  function automatic void encode_word(input logic [15:0] w, input logic eof);
    burst_words.delete();
    if (frame_armed) begin
      // The first word of a frame seeds the comparison and starts a run of one.
      prev_w      = w;
      run_len     = 0;
      lit_len     = 0;
      frame_armed = 1'b0;
    end
    if (w == prev_w) begin
      if (eof && lit_len > 0) begin
        // A repeat on the last word joins the pending literal.
        append_literal(w);
      end else begin
        emit_literal();
        run_len++;
        if (run_len >= int'(wrle_pkg::RUN_MAX)) begin
          emit_word({1'b0, wrle_pkg::RUN_MAX}, 1'b1);
          emit_word(prev_w, 1'b0);
          run_len = 0;
        end
      end
    end else begin
      close_run();
      prev_w = w;
      append_literal(w);
    end
    if (eof) begin
      close_run();
      emit_literal();
      frame_armed = 1'b1;
    end
    if (burst_words.size() > 0) begin
      burst_words[$].burst_end = 1'b1;
      burst_words[$].frame_end = eof;
    end
    foreach (burst_words[i]) begin
      owed_words.push_back(burst_words[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Sends one word and predicts its output at the edge where it is taken. Valid
  // stays high after acceptance, so back-to-back requests need no idle gap.
  task automatic send_word(input logic [15:0] w, input logic eof);
    int unsigned gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap != 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid        <= 1'b1;
    pix.pixel_word   <= w;
    pix.end_of_frame <= eof;
    do @(posedge clk_i); while (!pix.ready);
    encode_word(w, eof);
    words_sent++;
  endtask

  task automatic send_run(input logic [15:0] w, input int unsigned len, input logic eof);
    for (int unsigned k = 0; k < len; k++) begin
      send_word(w, eof && (k == len - 1));
    end
  endtask

  // Drops valid, waits for every owed word, then lets the encoder settle.
  task automatic wait_idle();
    pix.valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [3:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    thr = v;
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input bit on);
    src_max_gap = on ? 6 : 0;
    snk_max_gap = on ? 6 : 0;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h8000;
      3:       return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // A frame of one word is a run of one, so it leaves as a one-word literal.
  task automatic test_lone_word();
    send_word(16'hffff, 1'b1);
  endtask

  // Runs the reset threshold of four: a run pair, a literal closed by the end of
  // the frame, a repeat on the last word that joins the literal, and a short
  // run that is turned into a literal at the end of the frame.
  task automatic test_run_and_literal();
    send_run(16'h0000, 5, 1'b0);
    send_word(16'h1234, 1'b0);
    send_word(16'h5678, 1'b0);
    send_word(16'habcd, 1'b1);
    send_word(16'h0f0f, 1'b0);
    send_word(16'hf0f0, 1'b0);
    send_word(16'hf0f0, 1'b1);
    send_run(16'h8000, 3, 1'b1);
  endtask

  // Zero behaves as one, the largest threshold keeps short runs literal, and a
  // threshold of one turns a pair of words into a run.
  task automatic test_threshold_extremes();
    set_threshold(4'd0);
    send_run(16'h00ff, 2, 1'b0);
    send_word(16'h7f00, 1'b1);
    set_threshold(4'd15);
    send_run(16'h5a5a, 2, 1'b0);
    send_word(16'ha5a5, 1'b1);
    set_threshold(4'd1);
    send_run(16'h3333, 2, 1'b0);
    send_word(16'hcccc, 1'b1);
  endtask

  // Enough differing words to fill the literal buffer and start a second one.
  task automatic test_literal_fill();
    set_threshold(4'd4);
    for (int unsigned k = 0; k < 34; k++) begin
      send_word(16'(k * 16'h0b13 + 16'h0001), k == 33);
    end
  endtask

  // Random frames built from runs of every length around the thresholds, short
  // literals and now and then one about as long as the buffer. Each phase
  // picks a threshold and whether both sides idle.
  task automatic test_random_frames();
    int unsigned start_count;
    int unsigned nframes;
    int unsigned nseg;
    int unsigned len;
    int unsigned kind;
    logic [15:0] w;
    logic [15:0] frame_q[$];
    start_count = words_sent;
    while (words_sent - start_count < RANDOM_WORDS) begin
      case ($urandom_range(0, 5))
        0:       set_threshold(4'd0);
        1:       set_threshold(4'd1);
        2:       set_threshold(4'd15);
        default: set_threshold(4'($urandom_range(0, 15)));
      endcase
      set_idling($urandom_range(0, 3) != 0);
      nframes = $urandom_range(1, 3);
      repeat (nframes) begin
        frame_q.delete();
        nseg = $urandom_range(1, 5);
        repeat (nseg) begin
          kind = $urandom_range(0, 19);
          if (kind < 9) begin
            w   = pick_word();
            len = $urandom_range(1, 18);
            repeat (len) frame_q.push_back(w);
          end else if (kind < 19) begin
            len = $urandom_range(1, 6);
            repeat (len) frame_q.push_back(pick_word());
          end else begin
            len = $urandom_range(28, 36);
            repeat (len) frame_q.push_back(16'($urandom));
          end
        end
        foreach (frame_q[i]) begin
          send_word(frame_q[i], i == frame_q.size() - 1);
        end
      end
    end
    set_idling(1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Stream side: random stalls and the comparison of every accepted word.
  // ---------------------------------------------------------------------------

  initial begin : result_check
    int unsigned hold;
    enc_word_t   want;
    hold      = 0;
    enc.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (enc.valid && enc.ready) begin
        if (owed_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h hdr %b", enc.out_word, enc.is_header));
        end else begin
          want = owed_words.pop_front();
          if (enc.out_word !== want.word) begin
            report_mismatch($sformatf("out_word %h, expected %h", enc.out_word, want.word));
          end
          if (enc.is_header !== want.hdr) begin
            report_mismatch($sformatf("is_header %b, expected %b on word %h",
                                      enc.is_header, want.hdr, want.word));
          end
          if (enc.last_of_burst !== want.burst_end) begin
            report_mismatch($sformatf("last_of_burst %b, expected %b on word %h",
                                      enc.last_of_burst, want.burst_end, want.word));
          end
          if (enc.frame_done !== want.frame_end) begin
            report_mismatch($sformatf("frame_done %b, expected %b on word %h",
                                      enc.frame_done, want.frame_end, want.word));
          end
        end
        hold = $urandom_range(0, snk_max_gap);
        enc.ready <= (hold == 0);
      end else if (hold > 0) begin
        hold--;
        enc.ready <= (hold == 0);
      end else begin
        enc.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    pix.valid        = 1'b0;
    pix.pixel_word   = 16'h0000;
    pix.end_of_frame = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 4'd0;

    thr         = wrle_pkg::THR_RESET;
    prev_w      = 16'h0000;
    frame_armed = 1'b1;
    run_len     = 0;
    lit_len     = 0;
    set_idling(1'b1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_lone_word();
    test_run_and_literal();
    test_threshold_extremes();
    test_literal_fill();
    test_random_frames();

    wait_idle();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stops a hung run.
  initial begin
    #(RUN_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
